// ===== rtl/core/rmhcc_pkg.sv =====
// Shared types and constants of the region mean-hue colour classifier.
`timescale 1ns / 1ps
package rmhcc_pkg;

  localparam int CFG_W     = 14;
  localparam int CFG_IDX_W = 2;
  localparam int DIM_W     = 13;
  localparam int CHAN_W    = 8;
  localparam int CLASS_W   = 3;
  localparam int SUM_W     = 16;
  localparam int HUE_W     = 8;

  localparam int HUE_NUM     = 245760;
  localparam int DIV_N_W     = 18;
  localparam int DIV_D_W     = 9;
  localparam int DIV_STEPS   = 18;
  localparam int TAB_W       = 17;
  localparam int RAW_W       = 12;
  localparam int PROD_W      = 30;
  localparam int HUE_ROUND   = 2048;
  localparam int HUE_SHIFT   = 12;
  localparam int HUE_WRAP    = 180;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  localparam int HUE_RED_LOW     = 10;
  localparam int HUE_YELLOW_HIGH = 35;
  localparam int HUE_GREEN_HIGH  = 85;
  localparam int HUE_BLUE_HIGH   = 140;
  localparam int HUE_RED_HIGH    = 170;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_COL   = 2'd0,
    CFG_CENTER_ROW   = 2'd1,
    CFG_FRAME_WIDTH  = 2'd2,
    CFG_FRAME_HEIGHT = 2'd3
  } cfg_index_e;

  typedef enum logic [CLASS_W-1:0] {
    CLASS_RED     = 3'd0,
    CLASS_YELLOW  = 3'd1,
    CLASS_GREEN   = 3'd2,
    CLASS_BLUE    = 3'd3,
    CLASS_FUCHSIA = 3'd4,
    CLASS_UNKNOWN = 3'd5
  } color_class_e;

  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
    logic              frame_end;
  } pix_in_t;

  typedef struct packed {
    logic [CLASS_W-1:0] color_class;
    logic [SUM_W-1:0]   hue_total;
  } result_t;

  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
    logic              in_roi;
    logic              last;
    logic              region_valid;
  } token_t;

  typedef struct packed {
    logic [DIV_N_W-1:0]      n;
    logic [DIV_D_W-1:0]      d;
    logic [DIV_D_W-1:0]      rem;
    logic [DIV_N_W-1:0]      quo;
    logic signed [RAW_W-1:0] raw;
    logic                    zero;
    logic                    in_roi;
    logic                    last;
    logic                    region_valid;
  } div_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] prod;
    logic                     zero;
    logic                     in_roi;
    logic                     last;
    logic                     region_valid;
  } mul_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic             in_roi;
    logic             last;
    logic             region_valid;
  } hue_t;

endpackage

// ===== rtl/core/rmhcc_front.sv =====
// Front end: configuration registers, raster counters and region membership of each pixel.
`timescale 1ns / 1ps
module rmhcc_front #(
  parameter int WIN_SIZE   = 15,
  parameter int ROW_OFFSET = 35,
  parameter int MAX_DIM    = 4096
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [rmhcc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [rmhcc_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  rmhcc_pkg::pix_in_t                   in_word_i,
  input  logic                                 q_full_i,
  output logic                                 q_push_o,
  output rmhcc_pkg::token_t                    q_word_o
);
  import rmhcc_pkg::*;

  localparam int CNT_W = $clog2(MAX_DIM);

  logic signed [CFG_W-1:0] center_col_q, center_row_q;
  logic [DIM_W-1:0]        frame_width_q, frame_height_q;
  logic [CNT_W-1:0]        col_q, col_d, row_q, row_d;
  logic [CNT_W-1:0]        left_q, top_q, left_d, top_d;
  logic                    rvalid_q, rvalid_d;
  logic [DIM_W-1:0]        w_clamp, h_clamp;
  logic signed [15:0]      col_c, row_c;
  logic [CNT_W-1:0]        left_c, top_c, left_use, top_use;
  logic                    rvalid_c, rvalid_use, first, in_roi, accept;
  logic [CNT_W:0]          col_inc;

  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] place(logic signed [15:0] c, logic [DIM_W-1:0] size);
    logic signed [15:0] p;
    logic signed [15:0] lim;
    p   = c - signed'(16'(WIN_SIZE / 2));
    lim = signed'(16'(size)) - signed'(16'(WIN_SIZE));
    if (p < 16'sd0) p = 16'sd0;
    if (p > lim) p = lim;
    return p[CNT_W-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_col_q   <= '0;
      center_row_q   <= '0;
      frame_width_q  <= DIM_W'(640);
      frame_height_q <= DIM_W'(480);
    end else if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_CENTER_COL:   center_col_q   <= cfg_data_i;
        CFG_CENTER_ROW:   center_row_q   <= cfg_data_i;
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[DIM_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_clamp    = clamp_dim(frame_width_q);
    h_clamp    = clamp_dim(frame_height_q);
    col_c      = 16'(center_col_q);
    row_c      = 16'(center_row_q) + signed'(16'(ROW_OFFSET));
    rvalid_c   = (w_clamp >= DIM_W'(WIN_SIZE)) && (h_clamp >= DIM_W'(WIN_SIZE));
    left_c     = rvalid_c ? place(col_c, w_clamp) : '0;
    top_c      = rvalid_c ? place(row_c, h_clamp) : '0;
    first      = (col_q == '0) && (row_q == '0);
    left_use   = first ? left_c : left_q;
    top_use    = first ? top_c : top_q;
    rvalid_use = first ? rvalid_c : rvalid_q;
    in_roi     = rvalid_use &&
                 (col_q >= left_use) &&
                 ({1'b0, col_q} < {1'b0, left_use} + (CNT_W+1)'(WIN_SIZE)) &&
                 (row_q >= top_use) &&
                 ({1'b0, row_q} < {1'b0, top_use} + (CNT_W+1)'(WIN_SIZE));

    in_ready_o = !q_full_i;
    accept     = in_valid_i && !q_full_i;
    q_push_o   = accept;
    q_word_o.blue         = in_word_i.blue;
    q_word_o.green        = in_word_i.green;
    q_word_o.red          = in_word_i.red;
    q_word_o.in_roi       = in_roi;
    q_word_o.last         = in_word_i.frame_end;
    q_word_o.region_valid = rvalid_use;

    col_inc  = {1'b0, col_q} + (CNT_W+1)'(1);
    col_d    = col_q;
    row_d    = row_q;
    left_d   = left_q;
    top_d    = top_q;
    rvalid_d = rvalid_q;
    if (accept) begin
      left_d   = left_use;
      top_d    = top_use;
      rvalid_d = rvalid_use;
      if (in_word_i.frame_end) begin
        col_d = '0;
        row_d = '0;
      end else if (DIM_W'(col_inc) >= w_clamp) begin
        col_d = '0;
        if (row_q < CNT_W'(MAX_DIM - 1)) row_d = row_q + CNT_W'(1);
      end else begin
        col_d = col_inc[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      left_q   <= '0;
      top_q    <= '0;
      rvalid_q <= 1'b0;
    end else begin
      col_q    <= col_d;
      row_q    <= row_d;
      left_q   <= left_d;
      top_q    <= top_d;
      rvalid_q <= rvalid_d;
    end
  end

endmodule

// ===== rtl/core/rmhcc_queue.sv =====
// Short first-in first-out queue of pixel words between front and back end.
`timescale 1ns / 1ps
module rmhcc_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  rmhcc_pkg::token_t push_word_i,
  output logic              full_o,
  output logic              head_valid_o,
  output rmhcc_pkg::token_t head_word_o,
  input  logic              pop_i
);
  import rmhcc_pkg::*;

  token_t            mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   cnt_q, cnt_d;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_word_i;
  end

  always_comb begin
    full_o       = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
    head_valid_o = (cnt_q != '0);
    head_word_o  = mem_q[rd_ptr_q];
    cnt_d        = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + (QPTR_W+1)'(1);
    else if (pop_i && !push_i) cnt_d = cnt_q - (QPTR_W+1)'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      if (pop_i) rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== rtl/core/rmhcc_back.sv =====
// Back end: pipelined hue conversion, hue sum, result register and colour decision.
`timescale 1ns / 1ps
module rmhcc_back #(
  parameter int WIN_SIZE = 15
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  input  rmhcc_pkg::token_t   head_word_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rmhcc_pkg::result_t  out_word_o
);
  import rmhcc_pkg::*;

  localparam logic [19:0] T_RED_LOW     = 20'(HUE_RED_LOW * WIN_SIZE * WIN_SIZE);
  localparam logic [19:0] T_YELLOW_HIGH = 20'(HUE_YELLOW_HIGH * WIN_SIZE * WIN_SIZE);
  localparam logic [19:0] T_GREEN_HIGH  = 20'(HUE_GREEN_HIGH * WIN_SIZE * WIN_SIZE);
  localparam logic [19:0] T_BLUE_HIGH   = 20'(HUE_BLUE_HIGH * WIN_SIZE * WIN_SIZE);
  localparam logic [19:0] T_RED_HIGH    = 20'(HUE_RED_HIGH * WIN_SIZE * WIN_SIZE);

  div_t                  div_q [DIV_STEPS+1];
  div_t                  div_first;
  logic [DIV_STEPS:0]    div_vld_q;
  mul_t                  mul_q;
  logic                  mul_vld_q;
  hue_t                  hue_q;
  logic                  hue_vld_q;
  logic [SUM_W-1:0]      acc_q, acc_next;
  logic [SUM_W:0]        acc_sum;
  logic                  last_busy_q, last_busy_d;
  logic                  out_valid_q;
  logic [SUM_W-1:0]      out_sum_q;
  logic                  out_rvalid_q;
  logic [CHAN_W-1:0]     vmax, vmin, diff;
  logic signed [PROD_W-1:0] rounded;
  logic signed [PROD_W-HUE_SHIFT-1:0] hq;
  logic [HUE_W-1:0]      hue_c;
  logic [19:0]           sum_ext;
  color_class_e          cls;

  always_comb begin
    pop_o = head_valid_i && (!head_word_i.last || (!last_busy_q && !out_valid_q));

    vmax = head_word_i.blue;
    vmin = head_word_i.blue;
    if (head_word_i.green > vmax) vmax = head_word_i.green;
    if (head_word_i.red > vmax) vmax = head_word_i.red;
    if (head_word_i.green < vmin) vmin = head_word_i.green;
    if (head_word_i.red < vmin) vmin = head_word_i.red;
    diff = vmax - vmin;

    div_first.n    = DIV_N_W'(HUE_NUM) + DIV_N_W'(diff);
    div_first.d    = {diff, 1'b0};
    div_first.rem  = '0;
    div_first.quo  = '0;
    div_first.zero = (diff == '0);
    if (vmax == head_word_i.red)
      div_first.raw = signed'(RAW_W'(head_word_i.green)) - signed'(RAW_W'(head_word_i.blue));
    else if (vmax == head_word_i.green)
      div_first.raw = signed'(RAW_W'(head_word_i.blue)) - signed'(RAW_W'(head_word_i.red))
                      + signed'(RAW_W'({diff, 1'b0}));
    else
      div_first.raw = signed'(RAW_W'(head_word_i.red)) - signed'(RAW_W'(head_word_i.green))
                      + signed'(RAW_W'({diff, 2'b00}));
    div_first.in_roi       = head_word_i.in_roi;
    div_first.last         = head_word_i.last;
    div_first.region_valid = head_word_i.region_valid;
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) div_q[0] <= div_first;
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    localparam int B = DIV_STEPS - 1 - k;
    logic [DIV_D_W:0] sh, sub;
    logic             ge;
    div_t             nxt;
    always_comb begin
      sh  = {div_q[k].rem, div_q[k].n[B]};
      sub = sh - {1'b0, div_q[k].d};
      ge  = (sh >= {1'b0, div_q[k].d});
      nxt = div_q[k];
      nxt.rem    = ge ? sub[DIV_D_W-1:0] : sh[DIV_D_W-1:0];
      nxt.quo[B] = ge;
    end
    always_ff @(posedge clk_i) begin
      div_q[k+1] <= nxt;
    end
  end

  always_ff @(posedge clk_i) begin
    mul_q.prod <= {{(PROD_W-RAW_W){div_q[DIV_STEPS].raw[RAW_W-1]}}, div_q[DIV_STEPS].raw}
                  * signed'({(PROD_W-TAB_W)'(0), div_q[DIV_STEPS].quo[TAB_W-1:0]});
    mul_q.zero         <= div_q[DIV_STEPS].zero;
    mul_q.in_roi       <= div_q[DIV_STEPS].in_roi;
    mul_q.last         <= div_q[DIV_STEPS].last;
    mul_q.region_valid <= div_q[DIV_STEPS].region_valid;
  end

  always_comb begin
    rounded = mul_q.prod + signed'(PROD_W'(HUE_ROUND));
    hq      = rounded[PROD_W-1:HUE_SHIFT];
    if (mul_q.zero) hue_c = '0;
    else if (hq[PROD_W-HUE_SHIFT-1])
      hue_c = HUE_W'(hq + signed'((PROD_W-HUE_SHIFT)'(HUE_WRAP)));
    else hue_c = hq[HUE_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    hue_q.hue          <= hue_c;
    hue_q.in_roi       <= mul_q.in_roi;
    hue_q.last         <= mul_q.last;
    hue_q.region_valid <= mul_q.region_valid;
  end

  always_comb begin
    acc_sum  = {1'b0, acc_q} + (SUM_W+1)'(hue_q.hue);
    acc_next = acc_q;
    if (hue_q.in_roi) acc_next = acc_sum[SUM_W] ? '1 : acc_sum[SUM_W-1:0];
    last_busy_d = last_busy_q;
    if (hue_vld_q && hue_q.last) last_busy_d = 1'b0;
    if (pop_o && head_word_i.last) last_busy_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_vld_q   <= '0;
      mul_vld_q   <= 1'b0;
      hue_vld_q   <= 1'b0;
      acc_q       <= '0;
      last_busy_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      div_vld_q   <= {div_vld_q[DIV_STEPS-1:0], pop_o};
      mul_vld_q   <= div_vld_q[DIV_STEPS];
      hue_vld_q   <= mul_vld_q;
      last_busy_q <= last_busy_d;
      if (hue_vld_q && hue_q.last) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (hue_vld_q) begin
        if (hue_q.last) begin
          acc_q <= '0;
        end else begin
          acc_q <= acc_next;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (hue_vld_q && hue_q.last) begin
      out_sum_q    <= hue_q.region_valid ? acc_next : '0;
      out_rvalid_q <= hue_q.region_valid;
    end
  end

  always_comb begin
    sum_ext = 20'(out_sum_q);
    if (!out_rvalid_q) cls = CLASS_UNKNOWN;
    else if (sum_ext < T_RED_LOW || sum_ext >= T_RED_HIGH) cls = CLASS_RED;
    else if (sum_ext < T_YELLOW_HIGH) cls = CLASS_YELLOW;
    else if (sum_ext < T_GREEN_HIGH) cls = CLASS_GREEN;
    else if (sum_ext < T_BLUE_HIGH) cls = CLASS_BLUE;
    else cls = CLASS_FUCHSIA;
    out_valid_o            = out_valid_q;
    out_word_o.color_class = cls;
    out_word_o.hue_total   = out_sum_q;
  end

endmodule

// ===== rtl/core/roi_mean_hue_color_classifier.sv =====
// Top level of the region mean-hue colour classifier.
//
// Pixels arrive as words on the in channel (valid/ready) in raster order, one
// frame after another; frame_end marks the last pixel of a frame. The region
// is placed from the configuration at each frame's first pixel. Only the
// frame_end pixel yields a word on the out channel: the colour class and the
// hue sum of the region. Configuration is written through the plain write port.
// Throughput: one pixel per cycle. A frame_end pixel leaves the queue only once
// the previous result has been taken and no other frame_end is in flight.
// A frame_end pixel popped from the queue passes through the 18-step restoring
// divider that forms the hue reciprocal, then the multiplier, hue and sum stages,
// before out_valid_o is raised.
// When the receiver stalls, the result waits in the output register, the hue
// pipeline keeps draining pixels and the four-word queue absorbs the front end
// until it fills, at which point in_ready_o drops.
// Reset clears counters, pipeline valids and the sum, and loads the default
// configuration of a 640 x 480 frame with the centre at the origin.
`timescale 1ns / 1ps
module roi_mean_hue_color_classifier #(
  parameter int WIN_SIZE   = 15,
  parameter int ROW_OFFSET = 35,
  parameter int MAX_DIM    = 4096
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rmhcc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rmhcc_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  rmhcc_pkg::pix_in_t              in_word_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output rmhcc_pkg::result_t              out_word_o
);
  import rmhcc_pkg::*;

  logic   q_full, q_push, head_valid, pop;
  token_t push_word, head_word;

  rmhcc_front #(
    .WIN_SIZE  (WIN_SIZE),
    .ROW_OFFSET(ROW_OFFSET),
    .MAX_DIM   (MAX_DIM)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_word_o   (push_word)
  );

  rmhcc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_word_i (push_word),
    .full_o      (q_full),
    .head_valid_o(head_valid),
    .head_word_o (head_word),
    .pop_i       (pop)
  );

  rmhcc_back #(
    .WIN_SIZE(WIN_SIZE)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_word_i (head_word),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

// ===== verif/tb.sv =====
// Self-checking bench for the region mean-hue colour classifier against a hue-sum predictor.
`timescale 1ns / 1ps
module tb;
  import rmhcc_pkg::*;

  localparam int WIN_SIZE    = 15;
  localparam int ROW_OFFSET  = 35;
  localparam int MAX_DIM     = 4096;
  localparam int PIX_W       = $bits(pix_in_t);
  localparam int LAT_WAIT    = 40;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    bit                is_cfg;
    cfg_index_e        idx;
    logic [CFG_W-1:0]  data;
    pix_in_t           px;
    bit                typed;
    result_t           want;
  } step_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  pix_in_t              in_word_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  result_t              out_word_o;

  logic [CFG_W-1:0] ccol_r, crow_r;
  logic [DIM_W-1:0] width_r, height_r;
  int               col_pos, row_pos, hue_sum, roi_left, roi_top;
  bit               roi_ok;

  result_t due_classes[$];
  result_t oldest;
  step_t   plan[$];
  int      errors, words_in, frames, stalls, settings;
  int      class_hits[6];
  bit      calm, hold_req;

  roi_mean_hue_color_classifier #(
    .WIN_SIZE  (WIN_SIZE),
    .ROW_OFFSET(ROW_OFFSET),
    .MAX_DIM   (MAX_DIM)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int hue_of(int b, int g, int r);
    int hi, lo, span, recip, raw, h;
    hi = (b > g) ? b : g;
    hi = (r > hi) ? r : hi;
    lo = (b < g) ? b : g;
    lo = (r < lo) ? r : lo;
    span = hi - lo;
    if (span == 0) return 0;
    recip = (HUE_NUM + span) / (2 * span);
    if (hi == r) raw = g - b;
    else if (hi == g) raw = b - r + 2 * span;
    else raw = r - g + 4 * span;
    h = ((raw * recip + HUE_ROUND + (1 << 20)) >>> HUE_SHIFT) - 256;
    if (h < 0) h += HUE_WRAP;
    return h;
  endfunction

  function automatic int fit_dim(logic [DIM_W-1:0] v);
    if (v < 1) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  function automatic int place_corner(int centre, int span);
    int p;
    p = centre - WIN_SIZE / 2;
    if (p < 0) p = 0;
    if (p > span - WIN_SIZE) p = span - WIN_SIZE;
    return p;
  endfunction

  function automatic color_class_e classify_sum(int s);
    int n;
    n = WIN_SIZE * WIN_SIZE;
    if (s < HUE_RED_LOW * n || s >= HUE_RED_HIGH * n) return CLASS_RED;
    if (s < HUE_YELLOW_HIGH * n) return CLASS_YELLOW;
    if (s < HUE_GREEN_HIGH * n) return CLASS_GREEN;
    if (s < HUE_BLUE_HIGH * n) return CLASS_BLUE;
    return CLASS_FUCHSIA;
  endfunction

  task automatic roi_hue_step(input pix_in_t px, output bit fired, output result_t res);
    int w, h;
    w = fit_dim(width_r);
    if (col_pos == 0 && row_pos == 0) begin
      h = fit_dim(height_r);
      roi_ok = (w >= WIN_SIZE) && (h >= WIN_SIZE);
      roi_left = roi_ok ? place_corner(int'($signed(ccol_r)), w) : 0;
      roi_top = roi_ok ? place_corner(int'($signed(crow_r)) + ROW_OFFSET, h) : 0;
    end
    if (roi_ok && col_pos >= roi_left && col_pos < roi_left + WIN_SIZE &&
        row_pos >= roi_top && row_pos < roi_top + WIN_SIZE) begin
      hue_sum += hue_of(int'(px.blue), int'(px.green), int'(px.red));
      if (hue_sum > 65535) hue_sum = 65535;
    end
    fired = px.frame_end;
    res = '0;
    if (px.frame_end) begin
      res.color_class = roi_ok ? classify_sum(hue_sum) : CLASS_UNKNOWN;
      res.hue_total = roi_ok ? SUM_W'(hue_sum) : '0;
      col_pos = 0;
      row_pos = 0;
      hue_sum = 0;
    end else begin
      col_pos++;
      if (col_pos >= w) begin
        col_pos = 0;
        if (row_pos < MAX_DIM - 1) row_pos++;
      end
    end
  endtask

  function automatic step_t pix_step(int b, int g, int r, bit last);
    step_t s;
    s.is_cfg = 1'b0;
    s.idx = CFG_CENTER_COL;
    s.data = '0;
    s.px.blue = CHAN_W'(b);
    s.px.green = CHAN_W'(g);
    s.px.red = CHAN_W'(r);
    s.px.frame_end = last;
    s.typed = 1'b0;
    s.want = '0;
    return s;
  endfunction

  function automatic step_t reg_step(cfg_index_e idx, int val);
    step_t s;
    s = pix_step(0, 0, 0, 1'b0);
    s.is_cfg = 1'b1;
    s.idx = idx;
    s.data = CFG_W'(val);
    return s;
  endfunction

  function automatic step_t checked_step(int b, int g, int r, color_class_e cls, int total);
    step_t s;
    s = pix_step(b, g, r, 1'b1);
    s.typed = 1'b1;
    s.want.color_class = cls;
    s.want.hue_total = SUM_W'(total);
    return s;
  endfunction

  task automatic write_reg(input cfg_index_e idx, input logic [CFG_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_CENTER_COL:   ccol_r = val;
      CFG_CENTER_ROW:   crow_r = val;
      CFG_FRAME_WIDTH:  width_r = val[DIM_W-1:0];
      CFG_FRAME_HEIGHT: height_r = val[DIM_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic send_pixel(input pix_in_t px, input bit typed, input result_t want);
    bit      fired;
    result_t guess;
    while (!calm && $urandom_range(99) < 12) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i <= px;
    do @(posedge clk_i); while (!in_ready_o);
    roi_hue_step(px, fired, guess);
    words_in++;
    if (fired) begin
      due_classes.push_back(typed ? want : guess);
      frames++;
    end
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (due_classes.size() != 0) @(negedge clk_i);
    repeat (LAT_WAIT) @(negedge clk_i);
  endtask

  task automatic pick_setting();
    int pick, cc, cr, fw, fh;
    pick = $urandom_range(99);
    if (pick < 50) begin
      fw = $urandom_range(15, 24);
      fh = $urandom_range(15, 20);
      cc = $urandom_range(0, 30) - 4;
      cr = $urandom_range(0, 40) - 40;
      if ($urandom_range(9) == 0) cc = $urandom_range(1) ? 8191 : -8192;
      if ($urandom_range(9) == 0) cr = $urandom_range(1) ? 8191 : -8192;
    end else if (pick < 70) begin
      fw = $urandom_range(0, 14);
      fh = $urandom_range(0, 16383);
      if ($urandom_range(1)) begin
        fh = fw;
        fw = $urandom_range(0, 16383);
      end
      cc = $urandom_range(0, 16383);
      cr = $urandom_range(0, 16383);
    end else begin
      fw = $urandom_range(2) == 0 ? MAX_DIM : $urandom_range(0, 16383);
      fh = $urandom_range(2) == 0 ? MAX_DIM : $urandom_range(0, 16383);
      cc = $urandom_range(0, 16383);
      cr = $urandom_range(0, 16383);
    end
    write_reg(CFG_CENTER_COL, CFG_W'(cc));
    write_reg(CFG_CENTER_ROW, CFG_W'(cr));
    write_reg(CFG_FRAME_WIDTH, CFG_W'(fw));
    write_reg(CFG_FRAME_HEIGHT, CFG_W'(fh));
    cfg_we_i <= 1'b0;
    settings++;
  endtask

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else begin
        out_ready_i <= calm || ($urandom_range(99) >= 12);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_ready_o) stalls++;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (due_classes.size() == 0) begin
        $display("%0t: unexpected word, class %0d total %0d", $time,
                 out_word_o.color_class, out_word_o.hue_total);
        errors++;
      end else begin
        oldest = due_classes.pop_front();
        if (out_word_o.color_class !== oldest.color_class) begin
          $display("%0t: color_class expected %0d, got %0d", $time,
                   oldest.color_class, out_word_o.color_class);
          errors++;
        end
        if (out_word_o.hue_total !== oldest.hue_total) begin
          $display("%0t: hue_total expected %0d, got %0d", $time,
                   oldest.hue_total, out_word_o.hue_total);
          errors++;
        end
        if (out_word_o.color_class <= CLASS_UNKNOWN) class_hits[out_word_o.color_class]++;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    pix_in_t px, base;
    int      pick, len, phase, base_words, base_frames;
    bit      cfg_open;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_CENTER_COL;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    in_word_i = '0;
    ccol_r = '0;
    crow_r = '0;
    width_r = 640;
    height_r = 480;
    col_pos = 0;
    row_pos = 0;
    hue_sum = 0;
    roi_left = 0;
    roi_top = 0;
    roi_ok = 1'b0;
    calm = 1'b0;
    hold_req = 1'b0;
    cfg_open = 1'b0;
    settings = 1;

    plan.push_back(pix_step(10, 20, 30, 1'b0));
    plan.push_back(checked_step(255, 255, 255, CLASS_RED, 0));
    plan.push_back(reg_step(CFG_FRAME_WIDTH, 15));
    plan.push_back(reg_step(CFG_FRAME_HEIGHT, 15));
    plan.push_back(reg_step(CFG_CENTER_COL, -8192));
    plan.push_back(reg_step(CFG_CENTER_ROW, 8191));
    plan.push_back(pix_step(0, 0, 0, 1'b0));
    plan.push_back(pix_step(0, 0, 255, 1'b0));
    plan.push_back(pix_step(0, 255, 0, 1'b0));
    plan.push_back(pix_step(255, 0, 0, 1'b0));
    plan.push_back(pix_step(255, 0, 255, 1'b0));
    plan.push_back(pix_step(0, 255, 255, 1'b0));
    plan.push_back(pix_step(1, 0, 255, 1'b0));
    plan.push_back(pix_step(127, 128, 128, 1'b0));
    plan.push_back(pix_step(200, 200, 100, 1'b1));
    plan.push_back(reg_step(CFG_FRAME_WIDTH, 0));
    plan.push_back(checked_step(255, 255, 255, CLASS_UNKNOWN, 0));
    plan.push_back(reg_step(CFG_FRAME_WIDTH, 8191));
    plan.push_back(reg_step(CFG_FRAME_HEIGHT, 0));
    plan.push_back(checked_step(0, 0, 255, CLASS_UNKNOWN, 0));
    plan.push_back(reg_step(CFG_FRAME_WIDTH, 14));
    plan.push_back(reg_step(CFG_FRAME_HEIGHT, 4096));
    plan.push_back(checked_step(0, 255, 255, CLASS_UNKNOWN, 0));
    plan.push_back(reg_step(CFG_FRAME_WIDTH, 8191));
    plan.push_back(reg_step(CFG_CENTER_COL, 8191));
    plan.push_back(reg_step(CFG_CENTER_ROW, -8192));
    plan.push_back(pix_step(0, 0, 255, 1'b0));
    plan.push_back(pix_step(0, 255, 0, 1'b0));
    plan.push_back(checked_step(255, 255, 0, CLASS_RED, 0));
    plan.push_back(reg_step(CFG_FRAME_WIDTH, 15));
    plan.push_back(reg_step(CFG_FRAME_HEIGHT, 15));
    plan.push_back(reg_step(CFG_CENTER_COL, 0));
    plan.push_back(pix_step(40, 90, 200, 1'b0));
    plan.push_back(pix_step(0, 128, 255, 1'b0));
    plan.push_back(pix_step(255, 64, 0, 1'b0));
    plan.push_back(pix_step(90, 90, 90, 1'b0));
    plan.push_back(reg_step(CFG_FRAME_WIDTH, 20));
    plan.push_back(pix_step(30, 200, 60, 1'b0));
    plan.push_back(pix_step(180, 20, 220, 1'b0));
    plan.push_back(pix_step(5, 250, 5, 1'b1));

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        if (!cfg_open) begin
          wait_idle();
          settings++;
        end
        write_reg(plan[i].idx, plan[i].data);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) cfg_we_i <= 1'b0;
        cfg_open = 1'b0;
        send_pixel(plan[i].px, plan[i].typed, plan[i].want);
      end
    end

    base_words = words_in;
    base_frames = frames;
    phase = 0;
    while (words_in - base_words < 550 || frames - base_frames < 36) begin
      wait_idle();
      pick_setting();
      calm = (phase >= 3 && phase <= 5);
      if (phase == 1) begin
        hold_req = 1'b1;
        repeat (24) begin
          px = PIX_W'($urandom);
          px.frame_end = 1'b1;
          send_pixel(px, 1'b0, '0);
        end
      end
      repeat ($urandom_range(3, 8)) begin
        pick = $urandom_range(99);
        if (pick < 60) len = $urandom_range(1, 12);
        else if (pick < 95) len = $urandom_range(13, 110);
        else len = $urandom_range(111, 240);
        base = PIX_W'($urandom);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(99) < 20) begin
            px = PIX_W'($urandom);
          end else begin
            px = base;
            px.blue = base.blue ^ CHAN_W'($urandom_range(0, 7));
            px.green = base.green ^ CHAN_W'($urandom_range(0, 7));
            px.red = base.red ^ CHAN_W'($urandom_range(0, 7));
          end
          px.frame_end = (k == len - 1);
          send_pixel(px, 1'b0, '0);
        end
      end
      phase++;
    end
    calm = 1'b0;
    wait_idle();

    $display("covered %0d pixels in %0d frames over %0d settings, %0d cycles of input stall",
             words_in, frames, settings, stalls);
    $display("classes: red %0d yellow %0d green %0d blue %0d fuchsia %0d unknown %0d",
             class_hits[0], class_hits[1], class_hits[2], class_hits[3], class_hits[4],
             class_hits[5]);
    if (errors == 0 && due_classes.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
